// ===== hw/rtl/efp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types, constants and helpers for the escape-time fractal pixel unit.
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int unsigned FRAC_BITS = 26;
  localparam int unsigned FRAME_W   = 320;
  localparam int unsigned FRAME_H   = 240;

  localparam int unsigned ITER_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER = 3'd0,
    REG_C_REAL   = 3'd1,
    REG_C_IMAG   = 3'd2,
    REG_X_STEP   = 3'd3,
    REG_Y_STEP   = 3'd4
  } cfg_reg_e;

  // Reset values, rounded to nearest for the steps (4.0 / frame size)
  localparam longint FOUR_Q = longint'(4) << FRAC_BITS;
  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd24;
  localparam logic signed [31:0] C_RESET = 32'(-(longint'(2) << FRAC_BITS));
  localparam logic signed [31:0] X_STEP_RESET =
      32'((FOUR_Q + longint'(FRAME_W / 2)) / longint'(FRAME_W));
  localparam logic signed [31:0] Y_STEP_RESET =
      32'((FOUR_Q + longint'(FRAME_H / 2)) / longint'(FRAME_H));

  // |z|^2 escape threshold: 4.0 in the squared (2*FRAC_BITS) scale
  localparam logic [63:0] ESC_LIMIT = 64'd4 << (2 * FRAC_BITS);

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [ITER_W-1:0]  max_iter;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic signed [31:0] x_step;
    logic signed [31:0] y_step;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] uvx;
    logic signed [31:0] uvy;
  } uv_item_t;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > S32_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // RGB565 of r = 20n, g = 17n/2, b = 15n/2, each wrapped to 8 bits
  function automatic logic [15:0] pack_color(logic [ITER_W-1:0] n);
    logic [12:0] r20;
    logic [12:0] g17;
    logic [11:0] b15;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    r20 = 13'(n) * 13'd20;
    g17 = 13'(n) * 13'd17;
    b15 = 12'(n) * 12'd15;
    r = r20[7:0];
    g = g17[8:1];
    b = b15[8:1];
    if (n == '0) begin
      return 16'd0;
    end
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ===== hw/rtl/efp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_front
// Maps a pixel coordinate to its plane offset uv = (x*x_step, y*y_step).
// ----------------------------------------------------------------------------
module efp_front (
  input  logic [8:0]        pixel_x_i,
  input  logic [7:0]        pixel_y_i,
  input  efp_pkg::cfg_t     cfg_i,
  output efp_pkg::uv_item_t item_o
);

  logic signed [41:0] prod_x;
  logic signed [40:0] prod_y;

  assign prod_x = $signed({1'b0, pixel_x_i}) * $signed(cfg_i.x_step);
  assign prod_y = $signed({1'b0, pixel_y_i}) * $signed(cfg_i.y_step);

  assign item_o.uvx = efp_pkg::sat32(64'(prod_x));
  assign item_o.uvy = efp_pkg::sat32(64'(prod_y));

endmodule

// ===== hw/rtl/efp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_queue
// Short FIFO between the coordinate front end and the iteration engine.
// ----------------------------------------------------------------------------
module efp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  efp_pkg::uv_item_t wdata_i,
  input  logic              rd_i,
  output efp_pkg::uv_item_t rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  efp_pkg::uv_item_t mem [efp_pkg::QUEUE_DEPTH];

  logic [efp_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [efp_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [efp_pkg::QUEUE_PTR_W:0]   count_q, count_d;
  logic                            do_wr;
  logic                            do_rd;

  assign full_o  = (count_q == (efp_pkg::QUEUE_PTR_W + 1)'(efp_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == efp_pkg::QUEUE_PTR_W'(efp_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == efp_pkg::QUEUE_PTR_W'(efp_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/efp_iter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_iter
// Iteration engine: runs z = z^2 + c + uv until escape or the iteration
// limit, then holds the count and color in a one-entry result register.
// ----------------------------------------------------------------------------
module efp_iter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  efp_pkg::cfg_t                cfg_i,
  input  logic                         q_empty_i,
  input  efp_pkg::uv_item_t            q_data_i,
  output logic                         q_pop_o,
  input  logic                         pop,
  output logic                         empty,
  output logic [efp_pkg::ITER_W-1:0]   escape_count_o,
  output logic [15:0]                  pixel_color_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  logic signed [31:0] uvx_q, uvy_q;
  logic signed [31:0] zx_q, zx_d;
  logic signed [31:0] zy_q, zy_d;
  logic signed [63:0] pxx_q, pyy_q, pxy_q;
  logic [efp_pkg::ITER_W-1:0] k_q, k_d;
  logic [efp_pkg::ITER_W-1:0] count_q, count_d;

  logic                       out_valid_q, out_valid_d;
  logic [efp_pkg::ITER_W-1:0] out_count_q;
  logic [15:0]                out_color_q;

  logic               out_wr;
  logic [63:0]        mag;
  logic               escaped;
  logic signed [63:0] diff;
  logic signed [63:0] nx;
  logic signed [63:0] ny;

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign out_wr  = (state_q == ST_DONE) && (!out_valid_q || pop);

  // squared magnitude |z|^2 of the current z; it only counts once z came from an iteration
  assign mag     = $unsigned(pxx_q) + $unsigned(pyy_q);
  assign escaped = (k_q != '0) && (mag > efp_pkg::ESC_LIMIT);

  // arithmetic shifts give floor rounding
  assign diff = pxx_q - pyy_q;
  assign nx   = (diff >>> efp_pkg::FRAC_BITS) + 64'($signed(cfg_i.c_real))
              + 64'(uvx_q);
  assign ny   = (pxy_q >>> (efp_pkg::FRAC_BITS - 1)) + 64'($signed(cfg_i.c_imag))
              + 64'(uvy_q);

  always_comb begin
    state_d = state_q;
    zx_d    = zx_q;
    zy_d    = zy_q;
    k_d     = k_q;
    count_d = count_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          zx_d    = '0;
          zy_d    = '0;
          k_d     = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (escaped) begin
          count_d = k_q - 1'b1;
          state_d = ST_DONE;
        end else if (k_q == cfg_i.max_iter) begin
          count_d = k_q;
          state_d = ST_DONE;
        end else begin
          zx_d    = efp_pkg::sat32(nx);
          zy_d    = efp_pkg::sat32(ny);
          k_d     = k_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (out_wr) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_wr) begin
      out_valid_d = 1'b1;
    end else if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      uvx_q <= q_data_i.uvx;
      uvy_q <= q_data_i.uvy;
    end
    if (state_q == ST_MUL) begin
      pxx_q <= 64'(zx_q) * 64'(zx_q);
      pyy_q <= 64'(zy_q) * 64'(zy_q);
      pxy_q <= 64'(zx_q) * 64'(zy_q);
    end
    zx_q    <= zx_d;
    zy_q    <= zy_d;
    k_q     <= k_d;
    count_q <= count_d;
    if (out_wr) begin
      out_count_q <= count_q;
      out_color_q <= efp_pkg::pack_color(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty          = !out_valid_q;
  assign escape_count_o = out_count_q;
  assign pixel_color_o  = out_color_q;

endmodule

// ===== hw/rtl/escape_time_fractal_pixel_unit.sv =====
`timescale 1ns / 1ps
// Operation: one pixel in the iteration engine at a time; each iteration is a
// multiply state followed by an update/escape state. A 2-deep input queue
// and a one-entry result register let both sides run ahead.
// Reset: control state and the input queue clear, registers load their defaults.
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_unit
// Escape-time fractal pixel: coordinate in, iteration count and RGB565 out.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [efp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [efp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  logic [8:0]                        pixel_x_i,
  input  logic [7:0]                        pixel_y_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [efp_pkg::ITER_W-1:0]        escape_count_o,
  output logic [15:0]                       pixel_color_o
);

  efp_pkg::cfg_t     cfg_q;
  efp_pkg::uv_item_t front_item;
  efp_pkg::uv_item_t q_item;
  logic              q_empty;
  logic              q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iter <= efp_pkg::MAX_ITER_RESET;
      cfg_q.c_real   <= efp_pkg::C_RESET;
      cfg_q.c_imag   <= efp_pkg::C_RESET;
      cfg_q.x_step   <= efp_pkg::X_STEP_RESET;
      cfg_q.y_step   <= efp_pkg::Y_STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        efp_pkg::REG_MAX_ITER: cfg_q.max_iter <= cfg_data_i[efp_pkg::ITER_W-1:0];
        efp_pkg::REG_C_REAL:   cfg_q.c_real   <= $signed(cfg_data_i);
        efp_pkg::REG_C_IMAG:   cfg_q.c_imag   <= $signed(cfg_data_i);
        efp_pkg::REG_X_STEP:   cfg_q.x_step   <= $signed(cfg_data_i);
        efp_pkg::REG_Y_STEP:   cfg_q.y_step   <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  efp_front u_front (
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .cfg_i     (cfg_q),
    .item_o    (front_item)
  );

  efp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_item),
    .rd_i    (q_pop),
    .rdata_o (q_item),
    .full_o  (full),
    .empty_o (q_empty)
  );

  efp_iter u_iter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_empty),
    .q_data_i       (q_item),
    .q_pop_o        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .escape_count_o (escape_count_o),
    .pixel_color_o  (pixel_color_o)
  );

endmodule
